// ----- rtl/rlfm_pkg.sv -----
// rlfm_pkg: shared types and constants of the rgb line filter with mirror
// depends on nothing; imported by every module of the block
package rlfm_pkg;

  // pixel position within a line, wide enough for the longest line
  localparam int unsigned POS_W = 6;

  // filter constants
  localparam logic [7:0] CONTRAST_THR = 8'd128;
  localparam logic [7:0] CH_FULL      = 8'hFF;
  // floor(s / 3) == (s * 683) >> 11 for every s below 2048
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int unsigned RECIP3_SH   = 11;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_LINE_WIDTH      = 3'd0,
    CFG_MIRROR_ENABLE   = 3'd1,
    CFG_GREY_ENABLE     = 3'd2,
    CFG_NEGATE_MASK     = 3'd3,
    CFG_FLATTEN_MASK    = 3'd4,
    CFG_CONTRAST_ENABLE = 3'd5,
    CFG_MAX_COLOR       = 3'd6
  } cfg_idx_e;

  // configuration register set
  typedef struct packed {
    logic [6:0] line_width;
    logic       mirror_enable;
    logic       grey_enable;
    logic [2:0] negate_mask;
    logic [2:0] flatten_mask;
    logic       contrast_enable;
    logic [7:0] max_color;
  } cfg_t;

  // channel positions 0 (red), 1 (green), 2 (blue)
  typedef logic [2:0][7:0] pix_t;

  // filtered pixel handed from front to back
  typedef struct packed {
    pix_t             px;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             mirror;
  } entry_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } back_state_e;

endpackage

// ----- rtl/rlfm_if.sv -----
// rlfm_if: valid/ready channel interfaces of the rgb line filter
// pixel input, result output and configuration write; no dependencies
interface rlfm_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rlfm_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       end_of_line;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output end_of_line, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input end_of_line, output ready);
endinterface

interface rlfm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rlfm_front.sv -----
// rlfm_front: accepts pixels, tracks line position and applies the filters
// depends on rlfm_pkg and rlfm_pix_if
module rlfm_front
  import rlfm_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  rlfm_pix_if.sink in_i,
  output logic   push_o,
  output entry_t entry_o,
  input  logic   push_ready_i
);

  localparam logic [6:0] LW_MAX = 7'(LINE_MAX);

  logic [POS_W-1:0] fill_q, fill_d;
  logic [6:0]       w_eff;
  logic [6:0]       pos_nx;
  logic             last;
  logic [9:0]       sum;
  logic [19:0]      prod;
  logic [7:0]       avg;
  logic             accept;

  logic             s1_v_q;
  pix_t             s1_px_q;
  logic [POS_W-1:0] s1_pos_q;
  logic             s1_last_q;
  logic             s1_mirror_q;
  pix_t             filt;
  logic [7:0]       c;

  assign in_i.ready = !s1_v_q || push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // effective line width and end-of-line test
  always_comb begin
    if (cfg_i.line_width == '0) begin
      w_eff = 7'd1;
    end else if (cfg_i.line_width > LW_MAX) begin
      w_eff = LW_MAX;
    end else begin
      w_eff = cfg_i.line_width;
    end
    pos_nx = {1'b0, fill_q} + 7'd1;
    last   = (pos_nx >= w_eff);
    fill_d = last ? '0 : pos_nx[POS_W-1:0];
  end

  // grey average by reciprocal multiply
  assign sum  = 10'(in_i.red) + 10'(in_i.green) + 10'(in_i.blue);
  assign prod = 20'(sum) * 20'(RECIP3);
  assign avg  = prod[RECIP3_SH+7:RECIP3_SH];

  // line position counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
    end
  end

  // stage register between average and per-channel filters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (push_ready_i) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (cfg_i.grey_enable) begin
        s1_px_q <= {avg, avg, avg};
      end else begin
        s1_px_q <= {in_i.blue, in_i.green, in_i.red};
      end
      s1_pos_q    <= fill_q;
      s1_last_q   <= last;
      s1_mirror_q <= cfg_i.mirror_enable;
    end
  end

  // negate, flatten and threshold each channel
  always_comb begin
    filt = s1_px_q;
    c    = '0;
    for (int n = 0; n < 3; n++) begin
      c = s1_px_q[n];
      if (cfg_i.negate_mask[n]) begin
        c = (cfg_i.max_color >= c) ? (cfg_i.max_color - c) : 8'd0;
      end
      if (cfg_i.flatten_mask[n]) begin
        c = 8'd0;
      end
      if (cfg_i.contrast_enable) begin
        c = (c < CONTRAST_THR) ? 8'd0 : CH_FULL;
      end
      filt[n] = c;
    end
  end

  assign push_o         = s1_v_q;
  assign entry_o.px     = filt;
  assign entry_o.pos    = s1_pos_q;
  assign entry_o.last   = s1_last_q;
  assign entry_o.mirror = s1_mirror_q;

endmodule

// ----- rtl/rlfm_fifo.sv -----
// rlfm_fifo: two-entry queue of filtered pixels between front and back
// depends on rlfm_pkg
module rlfm_fifo
  import rlfm_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   push_ready_o,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   pop_valid_o
);

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/rlfm_back.sv -----
// rlfm_back: line store and output sequencer, emits pixels direct or mirrored
// depends on rlfm_pkg and rlfm_res_if
module rlfm_back
  import rlfm_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  entry_t q_data_i,
  output logic   q_pop_o,
  rlfm_res_if.source out_o
);

  localparam int unsigned AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  back_state_e      state_q, state_d;
  logic [POS_W-1:0] idx_q, idx_d;
  logic             out_v_q, out_v_d;
  pix_t             out_px_q, out_px_d;
  logic             out_eol_q, out_eol_d;
  logic             can_load;
  logic             mem_we;
  logic             mem_re;
  pix_t             line_store [LINE_MAX];
  pix_t             rd_data_q;

  assign can_load = !out_v_q || out_o.ready;

  // sequencer: store every pixel, emit direct or in reverse at end of line
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    out_v_d   = out_v_q && !out_o.ready;
    out_px_d  = out_px_q;
    out_eol_d = out_eol_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && ((q_data_i.mirror && !q_data_i.last) || can_load)) begin
          q_pop_o = 1'b1;
          mem_we  = 1'b1;
          if (!q_data_i.mirror) begin
            out_v_d   = 1'b1;
            out_px_d  = q_data_i.px;
            out_eol_d = q_data_i.last;
          end else if (q_data_i.last) begin
            out_v_d   = 1'b1;
            out_px_d  = q_data_i.px;
            out_eol_d = (q_data_i.pos == '0);
            if (q_data_i.pos != '0) begin
              idx_d   = q_data_i.pos - POS_W'(1);
              state_d = BK_READ;
            end
          end
        end
      end
      BK_READ: begin
        mem_re  = 1'b1;
        state_d = BK_LOAD;
      end
      BK_LOAD: begin
        if (can_load) begin
          out_v_d   = 1'b1;
          out_px_d  = rd_data_q;
          out_eol_d = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = BK_IDLE;
          end else begin
            idx_d   = idx_q - POS_W'(1);
            state_d = BK_READ;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    out_px_q  <= out_px_d;
    out_eol_q <= out_eol_d;
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_store[q_data_i.pos[AW-1:0]] <= q_data_i.px;
    end
    if (mem_re) begin
      rd_data_q <= line_store[idx_q[AW-1:0]];
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.red_out     = out_px_q[0];
  assign out_o.green_out   = out_px_q[1];
  assign out_o.blue_out    = out_px_q[2];
  assign out_o.end_of_line = out_eol_q;

endmodule

// ----- rtl/rgb_line_filter_with_mirror_top.sv -----
// rgb_line_filter_with_mirror_top: pixels pass the front stage, queue and output
// register; throughput without mirroring is one pixel per cycle while results are
// taken; mirrored pixels leave at line end (registered store read, then output load)
// reset: configuration to defaults, line position zero, queue and output empty;
// the line store is not cleared, every entry is written before it is read
// depends on rlfm_pkg, rlfm_if, rlfm_front, rlfm_fifo, rlfm_back
module rgb_line_filter_with_mirror_top
  import rlfm_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  rlfm_pix_if.sink   in_i,
  rlfm_res_if.source out_o,
  rlfm_cfg_if.sink   cfg_i
);

  cfg_t   cfg_q;
  logic   push;
  logic   push_ready;
  entry_t push_data;
  logic   pop;
  logic   pop_valid;
  entry_t pop_data;

  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width      <= 7'd64;
      cfg_q.mirror_enable   <= 1'b0;
      cfg_q.grey_enable     <= 1'b0;
      cfg_q.negate_mask     <= 3'd0;
      cfg_q.flatten_mask    <= 3'd0;
      cfg_q.contrast_enable <= 1'b0;
      cfg_q.max_color       <= 8'd255;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LINE_WIDTH:      cfg_q.line_width      <= cfg_i.data[6:0];
        CFG_MIRROR_ENABLE:   cfg_q.mirror_enable   <= cfg_i.data[0];
        CFG_GREY_ENABLE:     cfg_q.grey_enable     <= cfg_i.data[0];
        CFG_NEGATE_MASK:     cfg_q.negate_mask     <= cfg_i.data[2:0];
        CFG_FLATTEN_MASK:    cfg_q.flatten_mask    <= cfg_i.data[2:0];
        CFG_CONTRAST_ENABLE: cfg_q.contrast_enable <= cfg_i.data[0];
        CFG_MAX_COLOR:       cfg_q.max_color       <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // front: accept and filter
  rlfm_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_o       (push),
    .entry_o      (push_data),
    .push_ready_i (push_ready)
  );

  // queue between front and back
  rlfm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_data_o   (pop_data),
    .pop_valid_o  (pop_valid)
  );

  // back: line store and emission
  rlfm_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (pop_valid),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule

// ----- bench/rlfm_checker.sv -----
// rlfm_checker: watches the pixel, result and configuration channels of the rgb line filter
// predicts every filtered pixel and its line order, compares results field by field
// depends on rlfm_pkg and rlfm_if
module rlfm_checker
  import rlfm_pkg::*;
#(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rlfm_pix_if         pix,
  rlfm_res_if         res,
  rlfm_cfg_if         cfg,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // one predicted output pixel
  typedef struct packed {
    pix_t px;
    logic eol;
  } out_pixel_t;

  cfg_t       regs;
  pix_t       line_buf [LINE_MAX];
  int         line_pos;
  out_pixel_t expected_pixels[$];

  // grey, negate, flatten, contrast in that order
  function automatic pix_t filter_colors(pix_t raw);
    logic [9:0] total;
    pix_t       px;
    int         n;
    px = raw;
    if (regs.grey_enable) begin
      total = 10'(raw[0]) + 10'(raw[1]) + 10'(raw[2]);
      px = {3{8'(total / 10'd3)}};
    end
    for (n = 0; n < 3; n++) begin
      if (regs.negate_mask[n]) begin
        px[n] = (regs.max_color >= px[n]) ? regs.max_color - px[n] : 8'd0;
      end
      if (regs.flatten_mask[n]) begin
        px[n] = 8'd0;
      end
      if (regs.contrast_enable) begin
        px[n] = (px[n] < CONTRAST_THR) ? 8'd0 : CH_FULL;
      end
    end
    return px;
  endfunction

  // store the filtered pixel and queue what leaves the block for it
  task automatic predict_line_output(input pix_t raw);
    pix_t       px;
    out_pixel_t item;
    int         pos;
    int         width;
    int         i;
    bit         eol;
    px = filter_colors(raw);
    pos = line_pos;
    if (pos > int'(LINE_MAX) - 1) pos = int'(LINE_MAX) - 1;
    line_buf[pos] = px;
    width = int'(regs.line_width);
    if (width < 1) width = 1;
    if (width > int'(LINE_MAX)) width = int'(LINE_MAX);
    eol = (pos + 1 >= width);
    if (!regs.mirror_enable) begin
      item.px = px;
      item.eol = eol;
      expected_pixels.push_back(item);
    end else if (eol) begin
      // whole line leaves in reverse pixel order, channels stay in place
      for (i = pos; i >= 0; i--) begin
        item.px = line_buf[i];
        item.eol = (i == 0);
        expected_pixels.push_back(item);
      end
    end
    line_pos = eol ? 0 : pos + 1;
  endtask

  // compare one accepted result with the oldest prediction
  task automatic check_result();
    out_pixel_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected result: red_out %0d green_out %0d blue_out %0d end_of_line %0b",
             res.red_out, res.green_out, res.blue_out, res.end_of_line);
      fail_count_o++;
    end else begin
      want = expected_pixels.pop_front();
      if (res.red_out !== want.px[0]) begin
        $error("red_out: expected %0d, actual %0d", want.px[0], res.red_out);
        fail_count_o++;
      end
      if (res.green_out !== want.px[1]) begin
        $error("green_out: expected %0d, actual %0d", want.px[1], res.green_out);
        fail_count_o++;
      end
      if (res.blue_out !== want.px[2]) begin
        $error("blue_out: expected %0d, actual %0d", want.px[2], res.blue_out);
        fail_count_o++;
      end
      if (res.end_of_line !== want.eol) begin
        $error("end_of_line: expected %0b, actual %0b", want.eol, res.end_of_line);
        fail_count_o++;
      end
    end
  endtask

  // monitor all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{line_width: 7'd64, mirror_enable: 1'b0, grey_enable: 1'b0,
               negate_mask: 3'd0, flatten_mask: 3'd0, contrast_enable: 1'b0,
               max_color: 8'd255};
      line_pos = 0;
      expected_pixels.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_LINE_WIDTH:      regs.line_width = cfg.data[6:0];
          CFG_MIRROR_ENABLE:   regs.mirror_enable = cfg.data[0];
          CFG_GREY_ENABLE:     regs.grey_enable = cfg.data[0];
          CFG_NEGATE_MASK:     regs.negate_mask = cfg.data[2:0];
          CFG_FLATTEN_MASK:    regs.flatten_mask = cfg.data[2:0];
          CFG_CONTRAST_ENABLE: regs.contrast_enable = cfg.data[0];
          CFG_MAX_COLOR:       regs.max_color = cfg.data;
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        predict_line_output({pix.blue, pix.green, pix.red});
      end
      if (res.valid && res.ready) begin
        check_result();
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ----- bench/rgb_line_filter_with_mirror_top_tb.sv -----
// rgb_line_filter_with_mirror_top_tb: drives pixels, results backpressure and register writes
// directed filter and mirror cases first, then random lines; verdict from rlfm_checker
// depends on rlfm_pkg, rlfm_if, rlfm_checker and rgb_line_filter_with_mirror_top
module rgb_line_filter_with_mirror_top_tb;
  import rlfm_pkg::*;

  localparam int unsigned LINE_MAX       = 64;
  localparam int unsigned RAND_ITEMS     = 200;
  localparam int unsigned IDLE_SETTLE    = 8;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]  CFG_NONE_IDX   = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned stuck_cycles;
  bit          src_burst;
  bit          sink_burst;

  rlfm_pix_if pix_if ();
  rlfm_res_if res_if ();
  rlfm_cfg_if cfg_if ();

  rgb_line_filter_with_mirror_top #(
    .LINE_MAX(LINE_MAX)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (pix_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  rlfm_checker #(
    .LINE_MAX(LINE_MAX)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .pix         (pix_if),
    .res         (res_if),
    .cfg         (cfg_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // channel value biased toward the extremes and the contrast threshold
  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(126, 129));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one pixel request, valid stays high afterward
  task automatic send_pix(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  // register write once every expected result is out and the pipeline has settled
  task automatic set_reg(input logic [2:0] idx, input logic [7:0] value);
    pix_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // result backpressure, bursts of full throughput now and then
  initial begin
    int unsigned stall;
    int unsigned taken;
    res_if.ready <= 1'b0;
    sink_burst = 1'b0;
    taken = 0;
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      taken++;
      if (taken % 24 == 0) sink_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned sent;
    int unsigned count;
    int unsigned eff;
    logic [6:0]  width7;
    rst_n        <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.red   <= 8'd0;
    pix_if.green <= 8'd0;
    pix_if.blue  <= 8'd0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_LINE_WIDTH;
    cfg_if.data  <= 8'd0;
    src_burst = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: straight pass-through
    send_pix(8'd0, 8'd0, 8'd0);
    send_pix(8'hFF, 8'hFF, 8'hFF);
    send_pix(8'h55, 8'hAA, 8'h80);

    // zero width acts as one pixel per line, grey average truncates
    set_reg(CFG_LINE_WIDTH, 8'd0);
    set_reg(CFG_GREY_ENABLE, 8'd1);
    send_pix(8'hFF, 8'hFF, 8'hFF);
    send_pix(8'hFF, 8'hFF, 8'hFE);
    send_pix(8'd1, 8'd1, 8'd0);
    send_pix(8'd0, 8'd0, 8'd2);

    // oversize width clamps to the store depth, negation saturates at max color zero
    set_reg(CFG_LINE_WIDTH, 8'hFF);
    set_reg(CFG_GREY_ENABLE, 8'd0);
    set_reg(CFG_NEGATE_MASK, 8'd7);
    set_reg(CFG_MAX_COLOR, 8'd0);
    send_pix(8'd0, 8'd0, 8'd0);
    send_pix(8'd200, 8'd1, 8'hFF);

    // mirror turned on mid-line: pixels already sent come back reversed
    set_reg(CFG_MIRROR_ENABLE, 8'd1);
    set_reg(CFG_MAX_COLOR, 8'd100);
    set_reg(CFG_LINE_WIDTH, 8'd3);
    send_pix(8'd10, 8'd200, 8'd30);

    // width shrunk mid-line ends the line on the next pixel
    set_reg(CFG_MAX_COLOR, 8'hFF);
    set_reg(CFG_NEGATE_MASK, 8'd1);
    set_reg(CFG_FLATTEN_MASK, 8'd2);
    set_reg(CFG_CONTRAST_ENABLE, 8'd1);
    set_reg(CFG_LINE_WIDTH, 8'd6);
    send_pix(8'd127, 8'd50, 8'd127);
    send_pix(8'd128, 8'd9, 8'd128);
    send_pix(8'd0, 8'hFF, 8'hFF);
    send_pix(8'hFF, 8'd0, 8'd0);
    set_reg(CFG_LINE_WIDTH, 8'd2);
    send_pix(8'd100, 8'd100, 8'd100);

    // mirror turned off mid-line drops the stored pixels
    set_reg(CFG_CONTRAST_ENABLE, 8'd0);
    set_reg(CFG_FLATTEN_MASK, 8'd0);
    set_reg(CFG_NEGATE_MASK, 8'd0);
    set_reg(CFG_LINE_WIDTH, 8'd4);
    send_pix(8'd1, 8'd2, 8'd3);
    send_pix(8'd4, 8'd5, 8'd6);
    set_reg(CFG_MIRROR_ENABLE, 8'd0);
    send_pix(8'd7, 8'd8, 8'd9);
    send_pix(8'hF0, 8'h0F, 8'hAA);

    // unknown register index leaves everything as is
    set_reg(CFG_NONE_IDX, 8'hFF);
    send_pix(8'd1, 8'd2, 8'd3);

    // random settings, mostly whole lines of small width
    sent = 0;
    while (sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       width7 = 7'd0;
        1:       width7 = 7'd1;
        2:       width7 = 7'd64;
        3:       width7 = 7'($urandom_range(65, 127));
        4:       width7 = 7'($urandom_range(9, 63));
        default: width7 = 7'($urandom_range(2, 8));
      endcase
      set_reg(CFG_LINE_WIDTH, {1'($urandom_range(0, 1)), width7});
      if ($urandom_range(0, 1)) set_reg(CFG_MIRROR_ENABLE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) set_reg(CFG_GREY_ENABLE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) set_reg(CFG_NEGATE_MASK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) set_reg(CFG_FLATTEN_MASK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) set_reg(CFG_CONTRAST_ENABLE, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) set_reg(CFG_MAX_COLOR, rand_level());
      eff = (width7 == 0) ? 1 : (width7 > LINE_MAX) ? LINE_MAX : width7;
      if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, eff);
      end else begin
        count = eff * ((eff > 16) ? 1 : $urandom_range(1, 3));
      end
      src_burst = ($urandom_range(0, 3) == 0);
      repeat (count) begin
        send_pix(rand_level(), rand_level(), rand_level());
        sent++;
      end
    end
    pix_if.valid <= 1'b0;

    // drain, then let any stray result show up
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
